// ===== src/bfg_pkg.sv =====
// ----------------------------------------------------------------------------
// bfg_pkg: shared constants and tables for the grey-scale bilateral filter
// Holds the register map, border codes, line store geometry and exp tables.
// ----------------------------------------------------------------------------
package bfg_pkg;

  // Line store geometry: ring of 8 rows of 2048 pixels
  localparam int RingBits   = 3;
  localparam int ColBits    = 11;
  localparam int AddrBits   = RingBits + ColBits;
  localparam int StoreDepth = 1 << AddrBits;
  localparam int PixBits    = 8;
  localparam int MaxDim     = 2048;

  // Register indexes
  localparam logic [2:0] CfgWidth  = 3'd0;
  localparam logic [2:0] CfgHeight = 3'd1;
  localparam logic [2:0] CfgBorder = 3'd2;
  localparam logic [2:0] CfgRadius = 3'd3;
  localparam logic [2:0] CfgRowCoef = 3'd4;
  localparam logic [2:0] CfgColCoef = 3'd5;
  localparam logic [2:0] CfgRngCoef = 3'd6;

  // Border modes
  localparam logic [1:0] BorderZero   = 2'd0;
  localparam logic [1:0] BorderMirror = 2'd1;

  // exp(-i), Q1.16
  function automatic logic [16:0] exp_whole(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd24109;
      4'd2:  v = 17'd8869;
      4'd3:  v = 17'd3263;
      4'd4:  v = 17'd1200;
      4'd5:  v = 17'd442;
      4'd6:  v = 17'd162;
      4'd7:  v = 17'd60;
      4'd8:  v = 17'd22;
      4'd9:  v = 17'd8;
      4'd10: v = 17'd3;
      4'd11: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-j/16), Q1.16
  function automatic logic [16:0] exp_sixteenth(input logic [3:0] j);
    logic [16:0] v;
    case (j)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // exp(-k/256), Q1.16
  function automatic logic [16:0] exp_fine(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd65280;
      4'd2:  v = 17'd65026;
      4'd3:  v = 17'd64772;
      4'd4:  v = 17'd64520;
      4'd5:  v = 17'd64268;
      4'd6:  v = 17'd64018;
      4'd7:  v = 17'd63768;
      4'd8:  v = 17'd63520;
      4'd9:  v = 17'd63272;
      4'd10: v = 17'd63025;
      4'd11: v = 17'd62780;
      4'd12: v = 17'd62535;
      4'd13: v = 17'd62291;
      4'd14: v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

  // Symmetric reflection into 0..size-1 (index -k maps to k-1)
  function automatic logic [ColBits-1:0] reflect(input logic signed [12:0] v,
                                                 input logic [11:0] size);
    logic signed [13:0] sz;
    logic signed [13:0] vv;
    logic signed [13:0] t;
    sz = $signed({2'b00, size});
    vv = {v[12], v};
    if (vv < 14'sd0) begin
      t = -vv - 14'sd1;
    end else if (vv >= sz) begin
      t = (sz <<< 1) - 14'sd1 - vv;
    end else begin
      t = vv;
    end
    if (t < 14'sd0) t = 14'sd0;
    if (t >= sz) t = sz - 14'sd1;
    return t[ColBits-1:0];
  endfunction

endpackage

// ===== src/bilateral_filter_gray_core.sv =====
// ----------------------------------------------------------------------------
// bilateral_filter_gray_core: streaming grey-scale bilateral filter
// Line store ring in one synchronous RAM, tap loop over a shared weight unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transfer per pixel (in_tuser = 0) or flush tick (in_tuser = 1),
//            pixels in raster order. in_tready is high only while the core is
//            idle; one item is handled at a time.
//   out_*  : zero or one filtered pixel per input transfer, oldest centre first;
//            out_tlast marks the last pixel of the frame.
//   cfg_*  : register writes (index on cfg_addr), taken every cycle, to be
//            issued while the core is idle. Width, height or radius writes
//            restart the stream.
// Timing: an item that yields no pixel only passes through the check state.
//   One that yields a pixel walks every tap: each costs one line store read
//   and a 7-step weight pipeline that is shared by all taps; a 9-step
//   restoring divide follows. Dropped taps skip the weight pipeline.
// Stall: a finished pixel waits in the output register; the next item is
//   taken meanwhile and only its own result waits for the slot to free.
// Reset: counters clear, registers take their defaults (512x512, mirroring,
//   radius 3); the line store is not cleared and is written before use.
// ----------------------------------------------------------------------------
module bilateral_filter_gray_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_in
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] pixel_out, [18:8] out_row, [29:19] out_col
  output logic        out_tlast,  // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CENT  = 4'd2;
  localparam logic [3:0] S_ADDR  = 4'd3;
  localparam logic [3:0] S_Q     = 4'd4;
  localparam logic [3:0] S_P2    = 4'd5;
  localparam logic [3:0] S_P3    = 4'd6;
  localparam logic [3:0] S_P4    = 4'd7;
  localparam logic [3:0] S_P5    = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_DVI   = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  // Configuration registers
  logic [11:0] width_r, height_r;
  logic [1:0]  border_r, radius_r;
  logic [15:0] rcoef_r, ccoef_r, gcoef_r;

  // Stream counters
  logic [10:0] in_row_r, in_col_r, out_row_r, out_col_r;
  logic        full_r;
  logic [3:0]  state_r;

  // Per-centre datapath
  logic signed [3:0] ta_r, tb_r;
  logic [7:0]  p_r, q_r;
  logic        qzero_r;
  logic [20:0] xs_r;
  logic [15:0] dsq_r;
  logic [31:0] xr_r;
  logic [16:0] es1_r, es_r, er1_r, er_r, wt_r;
  logic [31:0] num_r, rem_r;
  logic [22:0] den_r;
  logic [8:0]  quot_r;
  logic [3:0]  dbit_r;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_pix_r;
  logic [10:0] out_row_o_r, out_col_o_r;
  logic        out_last_r;

  // Line store
  logic [7:0]  store [bfg_pkg::StoreDepth];
  logic [7:0]  rd_data_r;
  logic        rd_en, wr_en;
  logic [bfg_pkg::AddrBits-1:0] rd_addr, wr_addr;

  // Effective geometry
  logic [11:0] eff_w, eff_h, wm1, hm1;
  logic [1:0]  eff_n;
  always_comb begin
    if (width_r == 12'd0) eff_w = 12'd1;
    else if (width_r > 12'(bfg_pkg::MaxDim)) eff_w = 12'(bfg_pkg::MaxDim);
    else eff_w = width_r;
    if (height_r == 12'd0) eff_h = 12'd1;
    else if (height_r > 12'(bfg_pkg::MaxDim)) eff_h = 12'(bfg_pkg::MaxDim);
    else eff_h = height_r;
    eff_n = (radius_r == 2'd0) ? 2'd1 : radius_r;
    wm1 = eff_w - 12'd1;
    hm1 = eff_h - 12'd1;
  end

  // Input counter advance
  logic col_wrap, row_wrap;
  assign col_wrap = ({1'b0, in_col_r} + 12'd1) >= eff_w;
  assign row_wrap = ({1'b0, in_row_r} + 12'd1) >= eff_h;

  // Centre readiness
  logic [11:0] rr, cc, rr_c, cc_c;
  logic        ready;
  always_comb begin
    rr = {1'b0, out_row_r} + {10'd0, eff_n};
    cc = {1'b0, out_col_r} + {10'd0, eff_n};
    rr_c = (rr > hm1) ? hm1 : rr;
    cc_c = (cc > wm1) ? wm1 : cc;
    ready = full_r || ({1'b0, in_row_r} > rr_c) ||
            (({1'b0, in_row_r} == rr_c) && ({1'b0, in_col_r} > cc_c));
  end

  // Tap position, border test and reflection
  logic signed [3:0]  sn;
  logic signed [12:0] tr, tc;
  logic               tap_in, skip_tap, zero_tap, tap_last;
  logic [10:0]        mr, mc;
  logic [1:0]         ua, ub;
  logic [3:0]         asq, bsq;
  logic [20:0]        xs;
  always_comb begin
    sn = $signed({2'b00, eff_n});
    tr = $signed({2'b00, out_row_r}) + {{9{ta_r[3]}}, ta_r};
    tc = $signed({2'b00, out_col_r}) + {{9{tb_r[3]}}, tb_r};
    tap_in = (tr >= 13'sd0) && (tr < $signed({1'b0, eff_h})) &&
             (tc >= 13'sd0) && (tc < $signed({1'b0, eff_w}));
    skip_tap = !tap_in && (border_r != bfg_pkg::BorderZero) &&
               (border_r != bfg_pkg::BorderMirror);
    zero_tap = !tap_in && (border_r == bfg_pkg::BorderZero);
    mr = bfg_pkg::reflect(tr, eff_h);
    mc = bfg_pkg::reflect(tc, eff_w);
    ua = ta_r[3] ? 2'(-ta_r) : ta_r[1:0];
    ub = tb_r[3] ? 2'(-tb_r) : tb_r[1:0];
    asq = {2'b00, ua} * {2'b00, ua};
    bsq = {2'b00, ub} * {2'b00, ub};
    xs = 21'({4'd0, asq} * {4'd0, rcoef_r}) + 21'({4'd0, bsq} * {4'd0, ccoef_r});
    tap_last = (ta_r == sn) && (tb_r == sn);
  end

  // Weight pipeline products
  logic [7:0]  qv, dv;
  logic [33:0] m_es1, m_es, m_er1, m_er, m_wt;
  logic [31:0] dsh;
  always_comb begin
    qv = qzero_r ? 8'd0 : rd_data_r;
    dv = (p_r > qv) ? (p_r - qv) : (qv - p_r);
    m_es1 = bfg_pkg::exp_whole(xs_r[19:16]) * bfg_pkg::exp_sixteenth(xs_r[15:12])
            + 34'd32768;
    m_es  = es1_r * bfg_pkg::exp_fine(xs_r[11:8]) + 34'd32768;
    m_er1 = bfg_pkg::exp_whole(xr_r[19:16]) * bfg_pkg::exp_sixteenth(xr_r[15:12])
            + 34'd32768;
    m_er  = er1_r * bfg_pkg::exp_fine(xr_r[11:8]) + 34'd32768;
    m_wt  = es_r * er_r + 34'd32768;
    dsh   = {9'd0, den_r} << dbit_r;
  end

  // Line store ports
  always_comb begin
    wr_en   = (state_r == S_IDLE) && in_tvalid && !in_tuser[0] && !full_r;
    wr_addr = {in_row_r[bfg_pkg::RingBits-1:0], in_col_r};
    rd_en   = ((state_r == S_CHECK) && ready) ||
              ((state_r == S_ADDR) && !skip_tap && !zero_tap);
    rd_addr = (state_r == S_CHECK) ? {out_row_r[bfg_pkg::RingBits-1:0], out_col_r}
                                   : {mr[bfg_pkg::RingBits-1:0], mc};
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= in_tdata;
    if (rd_en) rd_data_r <= store[rd_addr];
  end

  // Handshakes
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_o_r, out_row_o_r, out_pix_r};
  assign out_tlast  = out_last_r;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_CHECK: begin
        num_r <= 32'd0;
        den_r <= 23'd0;
        ta_r  <= -sn;
        tb_r  <= -sn;
      end
      S_CENT: p_r <= rd_data_r;
      S_ADDR: begin
        xs_r    <= xs;
        qzero_r <= zero_tap;
        if (skip_tap) begin
          if (tb_r == sn) begin
            tb_r <= -sn;
            ta_r <= ta_r + 4'sd1;
          end else begin
            tb_r <= tb_r + 4'sd1;
          end
        end
      end
      S_Q: begin
        q_r   <= qv;
        dsq_r <= dv * dv;
        es1_r <= m_es1[32:16];
      end
      S_P2: begin
        xr_r <= dsq_r * gcoef_r;
        es_r <= xs_r[20] ? 17'd0 : m_es[32:16];
      end
      S_P3: er1_r <= m_er1[32:16];
      S_P4: er_r  <= (xr_r[31:20] != 12'd0) ? 17'd0 : m_er[32:16];
      S_P5: wt_r  <= m_wt[32:16];
      S_ACC: begin
        num_r <= num_r + ({15'd0, wt_r} * {24'd0, q_r});
        den_r <= den_r + 23'(wt_r);
        if (tb_r == sn) begin
          tb_r <= -sn;
          ta_r <= ta_r + 4'sd1;
        end else begin
          tb_r <= tb_r + 4'sd1;
        end
      end
      S_DVI: begin
        rem_r  <= num_r + {10'd0, den_r[22:1]};
        quot_r <= 9'd0;
        dbit_r <= 4'd8;
      end
      S_DIV: begin
        if (rem_r >= dsh) begin
          rem_r <= rem_r - dsh;
          quot_r[dbit_r] <= 1'b1;
        end
        dbit_r <= dbit_r - 4'd1;
      end
      default: ;
    endcase
  end

  // Control: state, counters, registers, output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= 12'd512;
      height_r    <= 12'd512;
      border_r    <= bfg_pkg::BorderMirror;
      radius_r    <= 2'd3;
      rcoef_r     <= 16'd33;
      ccoef_r     <= 16'd33;
      gcoef_r     <= 16'd1;
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // slot frees on transfer unless a new pixel is loaded below
      if (out_valid_r && out_tready && (state_r != S_FIN)) out_valid_r <= 1'b0;

      // register writes
      if (cfg_valid) begin
        case (cfg_addr)
          bfg_pkg::CfgWidth:   width_r  <= cfg_data[11:0];
          bfg_pkg::CfgHeight:  height_r <= cfg_data[11:0];
          bfg_pkg::CfgBorder:  border_r <= cfg_data[1:0];
          bfg_pkg::CfgRadius:  radius_r <= cfg_data[1:0];
          bfg_pkg::CfgRowCoef: rcoef_r  <= cfg_data;
          bfg_pkg::CfgColCoef: ccoef_r  <= cfg_data;
          bfg_pkg::CfgRngCoef: gcoef_r  <= cfg_data;
          default: ;
        endcase
        if (cfg_addr == bfg_pkg::CfgWidth || cfg_addr == bfg_pkg::CfgHeight ||
            cfg_addr == bfg_pkg::CfgRadius) begin
          in_row_r  <= '0;
          in_col_r  <= '0;
          out_row_r <= '0;
          out_col_r <= '0;
          full_r    <= 1'b0;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            if (wr_en) begin
              if (col_wrap) begin
                in_col_r <= '0;
                if (row_wrap) full_r <= 1'b1;
                else in_row_r <= in_row_r + 11'd1;
              end else begin
                in_col_r <= in_col_r + 11'd1;
              end
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: state_r <= ready ? S_CENT : S_IDLE;
        S_CENT:  state_r <= S_ADDR;
        S_ADDR: begin
          if (!skip_tap) state_r <= S_Q;
          else if (tap_last) state_r <= S_DVI;
        end
        S_Q:   state_r <= S_P2;
        S_P2:  state_r <= S_P3;
        S_P3:  state_r <= S_P4;
        S_P4:  state_r <= S_P5;
        S_P5:  state_r <= S_ACC;
        S_ACC: state_r <= tap_last ? S_DVI : S_ADDR;
        S_DVI: state_r <= S_DIV;
        S_DIV: if (dbit_r == 4'd0) state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            if (den_r == 23'd0) out_pix_r <= p_r;
            else if (quot_r[8]) out_pix_r <= 8'hFF;
            else out_pix_r <= quot_r[7:0];
            out_row_o_r <= out_row_r;
            out_col_o_r <= out_col_r;
            out_last_r  <= ({1'b0, out_row_r} == hm1) && ({1'b0, out_col_r} == wm1);
            if (({1'b0, out_row_r} == hm1) && ({1'b0, out_col_r} == wm1)) begin
              in_row_r  <= '0;
              in_col_r  <= '0;
              out_row_r <= '0;
              out_col_r <= '0;
              full_r    <= 1'b0;
            end else if ({1'b0, out_col_r} == wm1) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + 11'd1;
            end else begin
              out_col_r <= out_col_r + 11'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the grey-scale bilateral filter core
// Streams small frames under many register settings, predicts every filtered
// pixel with a behavioral model of the filter, and checks each output transfer
// in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BorderDrop  = 2'd2;
  localparam logic [1:0] BorderOdd   = 2'd3;
  localparam bit         CmdPixel    = 1'b0;
  localparam bit         CmdFlush    = 1'b1;
  localparam int         RingRows    = 8;
  localparam int         SettleCycles = 24;

  typedef struct packed {
    bit [7:0]  pix;
    bit [10:0] row;
    bit [10:0] col;
    bit        last;
  } filt_pix_t;

  // Scoreboard: behavioral filter plus queue of expected pixels
  class filter_scoreboard;
    bit [7:0]    line_ring[RingRows][2048];
    int unsigned in_row, in_col, out_row, out_col;
    bit          in_full;
    int unsigned width_reg, height_reg, border_reg, radius_reg;
    int unsigned row_coef, col_coef, rng_coef;
    filt_pix_t   expected_pixels[$];
    int          errors;
    int unsigned exp_int[16]  = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                  22, 8, 3, 1, 0, 0, 0, 0};
    int unsigned exp_sixt[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                  42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                  27319, 25664};
    int unsigned exp_frac[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                  63768, 63520, 63272, 63025, 62780, 62535, 62291,
                                  62048, 61806};

    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0; in_full = 0;
    endfunction

    function void reset_defaults();
      restart();
      width_reg = 512; height_reg = 512; border_reg = 1; radius_reg = 3;
      row_coef = 33; col_coef = 33; rng_coef = 1;
      errors = 0;
    endfunction

    function void apply_reg(logic [2:0] idx, bit [15:0] v);
      case (idx)
        bfg_pkg::CfgWidth:   begin width_reg = v[11:0]; restart(); end
        bfg_pkg::CfgHeight:  begin height_reg = v[11:0]; restart(); end
        bfg_pkg::CfgBorder:  border_reg = v[1:0];
        bfg_pkg::CfgRadius:  begin radius_reg = v[1:0]; restart(); end
        bfg_pkg::CfgRowCoef: row_coef = v;
        bfg_pkg::CfgColCoef: col_coef = v;
        bfg_pkg::CfgRngCoef: rng_coef = v;
        default: ;
      endcase
    endfunction

    // exp(-x) for x in Q16.16, zero from 12.0 up
    function longint unsigned neg_exp(longint unsigned x);
      longint unsigned v;
      if (x >= (64'd16 << 16)) return 0;
      v = longint'(exp_int[(x >> 16) & 15]) * exp_sixt[(x >> 12) & 15];
      v = (v + 32768) >> 16;
      v = (v * exp_frac[(x >> 8) & 15] + 32768) >> 16;
      return v;
    endfunction

    function int mirror_idx(int v, int size);
      if (v < 0) v = -v - 1;
      else if (v >= size) v = 2 * size - 1 - v;
      if (v < 0) v = 0;
      if (v >= size) v = size - 1;
      return v;
    endfunction

    function bit [7:0] filter_pixel(int w, int h, int n);
      int r, c, a, b;
      bit in_frame;
      int unsigned p, q, d;
      longint unsigned wt, num, den;
      p = line_ring[out_row % RingRows][out_col];
      num = 0; den = 0;
      for (a = -n; a <= n; a++) begin
        for (b = -n; b <= n; b++) begin
          r = out_row + a; c = out_col + b;
          in_frame = r >= 0 && r < h && c >= 0 && c < w;
          q = 0;
          if (in_frame || border_reg < 2) begin
            if (in_frame) begin
              q = line_ring[r % RingRows][c];
            end else if (border_reg == 1) begin
              r = mirror_idx(r, h);
              c = mirror_idx(c, w);
              q = line_ring[r % RingRows][c];
            end
            d = p > q ? p - q : q - p;
            wt = neg_exp(longint'(a * a) * row_coef + longint'(b * b) * col_coef);
            wt = (wt * neg_exp(longint'(d * d) * rng_coef) + 32768) >> 16;
            num += wt * q;
            den += wt;
          end
        end
      end
      if (den == 0) return p[7:0];
      num = (num + den / 2) / den;
      return num > 255 ? 8'hFF : num[7:0];
    endfunction

    // Advance the filter state for one accepted input transfer
    function void note_input(bit cmd, bit [7:0] pix);
      int w, h, n, rr, cc;
      bit ready;
      filt_pix_t e;
      w = width_reg == 0 ? 1 : (width_reg > 2048 ? 2048 : width_reg);
      h = height_reg == 0 ? 1 : (height_reg > 2048 ? 2048 : height_reg);
      n = radius_reg == 0 ? 1 : radius_reg;
      if (cmd == CmdPixel && !in_full) begin
        line_ring[in_row % RingRows][in_col] = pix;
        if (in_col + 1 >= w) begin
          in_col = 0;
          if (in_row + 1 >= h) in_full = 1;
          else in_row++;
        end else begin
          in_col++;
        end
      end
      if (in_full) begin
        ready = 1;
      end else begin
        rr = out_row + n; cc = out_col + n;
        if (rr > h - 1) rr = h - 1;
        if (cc > w - 1) cc = w - 1;
        ready = in_row > rr || (in_row == rr && in_col > cc);
      end
      if (!ready) return;
      e.pix = filter_pixel(w, h, n);
      e.row = out_row[10:0];
      e.col = out_col[10:0];
      e.last = out_row == h - 1 && out_col == w - 1;
      expected_pixels.push_back(e);
      if (e.last) restart();
      else if (out_col + 1 >= w) begin
        out_col = 0; out_row++;
      end else out_col++;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bit [31:0] data, bit last);
      filt_pix_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel data=%h last=%0b", data, last));
        return;
      end
      e = expected_pixels.pop_front();
      if (data[7:0] != e.pix || data[18:8] != e.row || data[29:19] != e.col ||
          last != e.last)
        report($sformatf("got pix=%0d row=%0d col=%0d last=%0b, want %0d %0d %0d %0b",
                         data[7:0], data[18:8], data[29:19], last,
                         e.pix, e.row, e.col, e.last));
    endtask

    function bit frame_open();
      return in_full || in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0;
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  filter_scoreboard sb = new();
  bit quiet = 0;
  int sent = 0;

  bilateral_filter_gray_core dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Result side: random backpressure, check every transfer
  always @(negedge clk) out_tready <= quiet || ($urandom_range(0, 99) >= 26);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  function bit idle_now();
    return !quiet && $urandom_range(0, 99) < 26;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  task send_item(bit cmd, bit [7:0] pix);
    while (idle_now()) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, pix);
    sent++;
    @(negedge clk);
  endtask

  task wait_idle();
    in_tvalid <= 0;
    while (sb.expected_pixels.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task write_reg(logic [2:0] idx, bit [15:0] v);
    cfg_valid <= 1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, v);
    @(negedge clk);
  endtask

  task configure(bit [15:0] w, bit [15:0] h, logic [1:0] border, bit [15:0] rad,
                 bit [15:0] rc, bit [15:0] cc, bit [15:0] gc);
    wait_idle();
    write_reg(bfg_pkg::CfgBorder, {14'd0, border});
    write_reg(bfg_pkg::CfgRowCoef, rc);
    write_reg(bfg_pkg::CfgColCoef, cc);
    write_reg(bfg_pkg::CfgRngCoef, gc);
    write_reg(bfg_pkg::CfgWidth, w);
    write_reg(bfg_pkg::CfgHeight, h);
    write_reg(bfg_pkg::CfgRadius, rad);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Flush out the tail of a completely received frame
  task drain_frame();
    while (sb.frame_open()) send_item(1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  function bit [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 64));
      3: return 16'($urandom_range(64, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  // One frame of pixels in raster order, with stray flush ticks, cut short on abort
  task send_frame(int npix, bit abort);
    int k, base, stop;
    bit smooth;
    smooth = $urandom_range(0, 9) < 7;
    base = $urandom_range(0, 255);
    stop = abort ? $urandom_range(0, npix) : npix;
    for (k = 0; k < stop; k++) begin
      if ($urandom_range(0, 9) == 0) send_item(CmdFlush, 8'($urandom));
      if (smooth) begin
        base = base + $urandom_range(0, 16) - 8;
        base = base < 0 ? 0 : (base > 255 ? 255 : base);
        send_item(CmdPixel, $urandom_range(0, 19) == 0 ? 8'($urandom) : 8'(base));
      end else begin
        send_item(CmdPixel, 8'($urandom));
      end
    end
    if (!abort) drain_frame();
  endtask

  initial begin
    int k, w, h, nfr;
    sb.reset_defaults();
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes in a 4x4 zero-padded frame, flush tick mid-frame
    configure(16'd4, 16'd4, bfg_pkg::BorderZero, 16'd1, 16'd0, 16'd0, 16'd0);
    for (k = 0; k < 16; k++) begin
      if (k == 7) send_item(CmdFlush, 8'hFF);
      send_item(CmdPixel, (k % 3 == 0) ? 8'h00 : ((k % 3 == 1) ? 8'hFF : 8'h55));
    end
    send_item(CmdPixel, 8'hAA);  // pixel after a full frame acts as flush
    drain_frame();
    // Radius wider than the frame, mirroring, strongest falloff
    configure(16'd2, 16'd2, bfg_pkg::BorderMirror, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(4, 0);
    // Zero sizes act as 1x1, radius 0 acts as 1, odd border code
    configure(16'd0, 16'd0, BorderOdd, 16'd0, 16'd1, 16'd1, 16'd1);
    send_frame(1, 0);

    // Oversize geometry: partial runs along the longest row and column
    configure(16'hFFFF, 16'd1, BorderDrop, 16'd1, 16'd33, 16'd33, 16'd1);
    send_frame(40, 1);
    configure(16'd1, 16'hFFFF, bfg_pkg::BorderMirror, 16'd2, 16'd33, 16'd33, 16'd1);
    send_frame(40, 1);
    configure(16'd2048, 16'd2, bfg_pkg::BorderZero, 16'd1, 16'd200, 16'd200, 16'd3);
    send_frame(30, 1);

    // Random phases; a phase runs without any idling with a chance of one in twelve
    while (sent < 1750) begin
      quiet = ($urandom_range(0, 11) == 0);
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 10);
      configure(16'(w), 16'(h), 2'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                pick_coef(), pick_coef(), pick_coef());
      nfr = $urandom_range(1, 2);
      for (k = 0; k < nfr; k++) send_frame(w * h, $urandom_range(0, 9) == 0);
    end
    quiet = 0;

    wait_idle();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/bfg_pkg.sv
src/bilateral_filter_gray_core.sv
dv/tb_top.sv
